// File: rtl/core/odometry_twist_correction_top_defines.svh
// ----------------------------------------------------------------------------
// Odometry twist correction assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ODOMETRY_TWIST_CORRECTION_TOP_DEFINES_SVH
`define ODOMETRY_TWIST_CORRECTION_TOP_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define OTC_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// The expression must hold at every edge outside reset.
`define OTC_ASSERT_ALWAYS(label, ck, rs, expr, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (expr)) else $error(msg);

// The consequent must hold in the cycle after reset is sampled high.
`define OTC_ASSERT_RESET(label, ck, rs, cons, msg) \
  label: assert property (@(posedge ck) (rs) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/otc_pkg.sv
// ----------------------------------------------------------------------------
// Odometry twist correction package
// Shared types, register map, widths and the microcode program.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package otc_pkg;

  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 49;
  localparam int STEP_W  = 5;

  // Squared norm at or below this value (Q.24) counts as standing still.
  localparam logic signed [ACC_W-1:0] SMALL_NORM_SQ = 49'sd1677;

  // Register map, word index within the configuration space.
  localparam logic [2:0] REG_COEF_XX = 3'd0;
  localparam logic [2:0] REG_COEF_XY = 3'd1;
  localparam logic [2:0] REG_COEF_XA = 3'd2;
  localparam logic [2:0] REG_COEF_YY = 3'd3;
  localparam logic [2:0] REG_COEF_YA = 3'd4;
  localparam logic [2:0] REG_COEF_AA = 3'd5;
  localparam logic [2:0] REG_SMOOTH  = 3'd6;
  localparam logic [2:0] REG_LIMITS  = 3'd7;

  // Component indexes.
  localparam logic [1:0] IDX_X = 2'd0;
  localparam logic [1:0] IDX_Y = 2'd1;
  localparam logic [1:0] IDX_A = 2'd2;

  // Program entry points.
  localparam logic [STEP_W-1:0] STEP_ENTRY = 5'd0;
  localparam logic [STEP_W-1:0] STEP_RAW   = 5'd20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_NORM,
    MUL_BLEND,
    MUL_SQ,
    MUL_MAT
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_BLEND
  } acc_op_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_NORM,
    WB_FILT,
    WB_SQ,
    WB_OUT,
    WB_RAW
  } wb_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_END,
    SEQ_BR_UNPRIMED
  } seq_op_t;

  typedef struct packed {
    mul_op_t           mul_op;
    logic [1:0]        mul_idx;
    logic [1:0]        mat_row;
    acc_op_t           acc_op;
    wb_op_t            wb_op;
    logic [1:0]        wb_idx;
    seq_op_t           seq_op;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic   load;
    logic   run;
    ucode_t uc;
  } dp_ctl_t;

  typedef struct packed {
    logic signed [15:0] coef_xx;
    logic signed [15:0] coef_xy;
    logic signed [15:0] coef_xa;
    logic signed [15:0] coef_yy;
    logic signed [15:0] coef_ya;
    logic signed [15:0] coef_aa;
    logic        [15:0] smoothing;
    logic        [15:0] lim_lin;
    logic        [15:0] lim_ang;
  } cfg_t;

  // Each word may issue one multiply, fold the previous product into the
  // accumulator and write back the accumulator value of the step before.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uc;
    unique case (step)
      5'd0:  uc = '{MUL_NORM,  IDX_X, IDX_X, ACC_HOLD,  WB_NONE, IDX_X, SEQ_BR_UNPRIMED,
                   STEP_RAW};
      5'd1:  uc = '{MUL_NORM,  IDX_Y, IDX_X, ACC_LOAD,  WB_NONE, IDX_X, SEQ_NEXT, STEP_ENTRY};
      5'd2:  uc = '{MUL_NORM,  IDX_A, IDX_X, ACC_ADD,   WB_NONE, IDX_X, SEQ_NEXT, STEP_ENTRY};
      5'd3:  uc = '{MUL_BLEND, IDX_X, IDX_X, ACC_ADD,   WB_NONE, IDX_X, SEQ_NEXT, STEP_ENTRY};
      5'd4:  uc = '{MUL_BLEND, IDX_Y, IDX_X, ACC_BLEND, WB_NORM, IDX_X, SEQ_NEXT, STEP_ENTRY};
      5'd5:  uc = '{MUL_BLEND, IDX_A, IDX_X, ACC_BLEND, WB_FILT, IDX_X, SEQ_NEXT, STEP_ENTRY};
      5'd6:  uc = '{MUL_SQ,    IDX_X, IDX_X, ACC_BLEND, WB_FILT, IDX_Y, SEQ_NEXT, STEP_ENTRY};
      5'd7:  uc = '{MUL_SQ,    IDX_Y, IDX_X, ACC_LOAD,  WB_FILT, IDX_A, SEQ_NEXT, STEP_ENTRY};
      5'd8:  uc = '{MUL_SQ,    IDX_A, IDX_X, ACC_LOAD,  WB_SQ,   IDX_X, SEQ_NEXT, STEP_ENTRY};
      5'd9:  uc = '{MUL_MAT,   IDX_X, IDX_X, ACC_LOAD,  WB_SQ,   IDX_Y, SEQ_NEXT, STEP_ENTRY};
      5'd10: uc = '{MUL_MAT,   IDX_Y, IDX_X, ACC_LOAD,  WB_SQ,   IDX_A, SEQ_NEXT, STEP_ENTRY};
      5'd11: uc = '{MUL_MAT,   IDX_A, IDX_X, ACC_ADD,   WB_NONE, IDX_X, SEQ_NEXT, STEP_ENTRY};
      5'd12: uc = '{MUL_MAT,   IDX_X, IDX_Y, ACC_ADD,   WB_NONE, IDX_X, SEQ_NEXT, STEP_ENTRY};
      5'd13: uc = '{MUL_MAT,   IDX_Y, IDX_Y, ACC_LOAD,  WB_OUT,  IDX_X, SEQ_NEXT, STEP_ENTRY};
      5'd14: uc = '{MUL_MAT,   IDX_A, IDX_Y, ACC_ADD,   WB_NONE, IDX_X, SEQ_NEXT, STEP_ENTRY};
      5'd15: uc = '{MUL_MAT,   IDX_X, IDX_A, ACC_ADD,   WB_NONE, IDX_X, SEQ_NEXT, STEP_ENTRY};
      5'd16: uc = '{MUL_MAT,   IDX_Y, IDX_A, ACC_LOAD,  WB_OUT,  IDX_Y, SEQ_NEXT, STEP_ENTRY};
      5'd17: uc = '{MUL_MAT,   IDX_A, IDX_A, ACC_ADD,   WB_NONE, IDX_X, SEQ_NEXT, STEP_ENTRY};
      5'd18: uc = '{MUL_NONE,  IDX_X, IDX_X, ACC_ADD,   WB_NONE, IDX_X, SEQ_NEXT, STEP_ENTRY};
      5'd19: uc = '{MUL_NONE,  IDX_X, IDX_X, ACC_HOLD,  WB_OUT,  IDX_A, SEQ_END,  STEP_ENTRY};
      5'd20: uc = '{MUL_NONE,  IDX_X, IDX_X, ACC_HOLD,  WB_RAW,  IDX_X, SEQ_END,  STEP_ENTRY};
      default: uc = '{MUL_NONE, IDX_X, IDX_X, ACC_HOLD, WB_NONE, IDX_X, SEQ_END, STEP_ENTRY};
    endcase
    return uc;
  endfunction

endpackage

// File: rtl/core/odometry_twist_correction_top.sv
// Each sample runs 20 microcode steps through the single shared multiplier;
// the first sample after reset branches from the entry step to the raw
// step. The result then moves into the output register, waiting while a
// held beat is not taken; the block then returns to idle for the next sample.
// Reset restores the register defaults and forgets the stored first sample.
// ----------------------------------------------------------------------------
// Odometry twist correction top level
// Step sequencer reading the microcode table, configuration port, datapath
// and a held output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module odometry_twist_correction_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] vel_ang,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [35:0] corr_x,
  output logic signed [35:0] corr_y,
  output logic signed [35:0] corr_ang
);

  otc_pkg::ctrl_state_t             state;
  otc_pkg::ctrl_state_t             state_next;
  logic [otc_pkg::STEP_W-1:0]       step;
  logic [otc_pkg::STEP_W-1:0]       step_next;
  logic                             primed;
  otc_pkg::ucode_t                  uc;
  otc_pkg::dp_ctl_t                 dp_ctl;
  otc_pkg::cfg_t                    cfg;
  logic                             in_fire;
  logic                             emit_fire;
  logic signed [35:0]               res_x;
  logic signed [35:0]               res_y;
  logic signed [35:0]               res_ang;

  assign pready = 1'b1;
  assign uc     = otc_pkg::ucode_rom(step);

  otc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  otc_datapath u_datapath (
    .clk     (clk),
    .ctl     (dp_ctl),
    .cfg     (cfg),
    .vel_x   (vel_x),
    .vel_y   (vel_y),
    .vel_ang (vel_ang),
    .res_x   (res_x),
    .res_y   (res_y),
    .res_ang (res_ang)
  );

  // Next state and step.
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      otc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = otc_pkg::ST_RUN;
          step_next  = otc_pkg::STEP_ENTRY;
        end
      end
      otc_pkg::ST_RUN: begin
        unique case (uc.seq_op)
          otc_pkg::SEQ_END:         state_next = otc_pkg::ST_EMIT;
          otc_pkg::SEQ_BR_UNPRIMED: step_next  = primed ? step + 1'b1 : uc.target;
          default:                  step_next  = step + 1'b1;
        endcase
      end
      otc_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = otc_pkg::ST_IDLE;
        end
      end
      default: state_next = otc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready      = 1'b0;
    emit_fire     = 1'b0;
    dp_ctl.load   = 1'b0;
    dp_ctl.run    = 1'b0;
    dp_ctl.uc     = uc;
    unique case (state)
      otc_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        dp_ctl.load = in_valid;
      end
      otc_pkg::ST_RUN:  dp_ctl.run = 1'b1;
      otc_pkg::ST_EMIT: emit_fire  = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= otc_pkg::ST_IDLE;
      step      <= otc_pkg::STEP_ENTRY;
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (dp_ctl.run && (uc.wb_op == otc_pkg::WB_RAW)) begin
        primed <= 1'b1;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      corr_x   <= res_x;
      corr_y   <= res_y;
      corr_ang <= res_ang;
    end
  end

endmodule

// File: rtl/core/otc_regs.sv
// ----------------------------------------------------------------------------
// Odometry twist correction configuration registers
// APB-style register file holding the matrix, filter weight and limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module otc_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output otc_pkg::cfg_t       cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_xx   <= 16'sd0;
      cfg.coef_xy   <= 16'sd0;
      cfg.coef_xa   <= 16'sd0;
      cfg.coef_yy   <= 16'sd0;
      cfg.coef_ya   <= 16'sd0;
      cfg.coef_aa   <= 16'sd4096;
      cfg.smoothing <= 16'h8000;
      cfg.lim_lin   <= 16'hFFFF;
      cfg.lim_ang   <= 16'hFFFF;
    end else if (wr_en) begin
      unique case (reg_idx)
        otc_pkg::REG_COEF_XX: cfg.coef_xx   <= pwdata[15:0];
        otc_pkg::REG_COEF_XY: cfg.coef_xy   <= pwdata[15:0];
        otc_pkg::REG_COEF_XA: cfg.coef_xa   <= pwdata[15:0];
        otc_pkg::REG_COEF_YY: cfg.coef_yy   <= pwdata[15:0];
        otc_pkg::REG_COEF_YA: cfg.coef_ya   <= pwdata[15:0];
        otc_pkg::REG_COEF_AA: cfg.coef_aa   <= pwdata[15:0];
        otc_pkg::REG_SMOOTH:  cfg.smoothing <= pwdata[15:0];
        otc_pkg::REG_LIMITS: begin
          cfg.lim_lin <= pwdata[31:16];
          cfg.lim_ang <= pwdata[15:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      otc_pkg::REG_COEF_XX: prdata = {16'd0, cfg.coef_xx};
      otc_pkg::REG_COEF_XY: prdata = {16'd0, cfg.coef_xy};
      otc_pkg::REG_COEF_XA: prdata = {16'd0, cfg.coef_xa};
      otc_pkg::REG_COEF_YY: prdata = {16'd0, cfg.coef_yy};
      otc_pkg::REG_COEF_YA: prdata = {16'd0, cfg.coef_ya};
      otc_pkg::REG_COEF_AA: prdata = {16'd0, cfg.coef_aa};
      otc_pkg::REG_SMOOTH:  prdata = {16'd0, cfg.smoothing};
      otc_pkg::REG_LIMITS:  prdata = {cfg.lim_lin, cfg.lim_ang};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/core/otc_datapath.sv
// ----------------------------------------------------------------------------
// Odometry twist correction datapath
// One shared multiplier, an accumulator and the filter, square and result
// registers, all steered by the current control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module otc_datapath (
  input  logic                clk,
  input  otc_pkg::dp_ctl_t    ctl,
  input  otc_pkg::cfg_t       cfg,
  input  logic signed [15:0]  vel_x,
  input  logic signed [15:0]  vel_y,
  input  logic signed [15:0]  vel_ang,
  output logic signed [35:0]  res_x,
  output logic signed [35:0]  res_y,
  output logic signed [35:0]  res_ang
);

  logic signed [15:0]                  v     [3];
  logic signed [15:0]                  filt  [3];
  logic signed [31:0]                  sq    [3];
  logic signed [35:0]                  corr  [3];
  logic signed [15:0]                  v_pipe;
  logic signed [otc_pkg::ACC_W-1:0]    prod;
  logic signed [otc_pkg::ACC_W-1:0]    acc;
  logic                                at_rest;

  logic signed [15:0]                  v_sel;
  logic signed [15:0]                  f_sel;
  logic signed [31:0]                  s_sel;
  logic        [16:0]                  diff;
  logic        [16:0]                  f_ext;
  logic        [16:0]                  f_abs;
  logic        [15:0]                  lim;
  logic        [16:0]                  mag;
  logic        [17:0]                  mag_ext;
  logic signed [15:0]                  coef;
  logic signed [otc_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [otc_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [otc_pkg::MUL_P_W-1:0]  mul_p;

  assign res_x   = corr[0];
  assign res_y   = corr[1];
  assign res_ang = corr[2];

  // Operand selection: the clamp works on magnitudes, so the clamped square
  // is min(|f|, limit) squared, with the sign folded into one operand.
  always_comb begin
    v_sel   = v[ctl.uc.mul_idx];
    f_sel   = filt[ctl.uc.mul_idx];
    s_sel   = sq[ctl.uc.mul_idx];
    diff    = {f_sel[15], f_sel} - {v_sel[15], v_sel};
    f_ext   = {f_sel[15], f_sel};
    f_abs   = f_sel[15] ? (17'd0 - f_ext) : f_ext;
    lim     = (ctl.uc.mul_idx == otc_pkg::IDX_A) ? cfg.lim_ang : cfg.lim_lin;
    mag     = (f_abs < {1'b0, lim}) ? f_abs : {1'b0, lim};
    mag_ext = {1'b0, mag};

    unique case ({ctl.uc.mat_row, ctl.uc.mul_idx})
      {otc_pkg::IDX_X, otc_pkg::IDX_X}: coef = cfg.coef_xx;
      {otc_pkg::IDX_X, otc_pkg::IDX_Y},
      {otc_pkg::IDX_Y, otc_pkg::IDX_X}: coef = cfg.coef_xy;
      {otc_pkg::IDX_X, otc_pkg::IDX_A},
      {otc_pkg::IDX_A, otc_pkg::IDX_X}: coef = cfg.coef_xa;
      {otc_pkg::IDX_Y, otc_pkg::IDX_Y}: coef = cfg.coef_yy;
      {otc_pkg::IDX_Y, otc_pkg::IDX_A},
      {otc_pkg::IDX_A, otc_pkg::IDX_Y}: coef = cfg.coef_ya;
      {otc_pkg::IDX_A, otc_pkg::IDX_A}: coef = cfg.coef_aa;
      default:                          coef = 16'sd0;
    endcase

    unique case (ctl.uc.mul_op)
      otc_pkg::MUL_NORM: begin
        mul_a = {{2{v_sel[15]}}, v_sel};
        mul_b = {{17{v_sel[15]}}, v_sel};
      end
      otc_pkg::MUL_BLEND: begin
        // a*old + (1-a)*v is v + a*(old - v) in Q0.16.
        mul_a = {2'b00, cfg.smoothing};
        mul_b = {{16{diff[16]}}, diff};
      end
      otc_pkg::MUL_SQ: begin
        mul_a = f_sel[15] ? (18'd0 - mag_ext) : mag_ext;
        mul_b = {16'd0, mag};
      end
      otc_pkg::MUL_MAT: begin
        mul_a = {{2{coef[15]}}, coef};
        mul_b = {s_sel[31], s_sel};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v[0] <= vel_x;
      v[1] <= vel_y;
      v[2] <= vel_ang;
    end
    if (ctl.run) begin
      prod   <= mul_p[otc_pkg::ACC_W-1:0];
      v_pipe <= v_sel;

      unique case (ctl.uc.acc_op)
        otc_pkg::ACC_LOAD:  acc <= prod;
        otc_pkg::ACC_ADD:   acc <= acc + prod;
        otc_pkg::ACC_BLEND: acc <= prod + {{17{v_pipe[15]}}, v_pipe, 16'd0};
        default: ;
      endcase

      unique case (ctl.uc.wb_op)
        otc_pkg::WB_NORM: at_rest <= (acc <= otc_pkg::SMALL_NORM_SQ);
        otc_pkg::WB_FILT: filt[ctl.uc.wb_idx] <= at_rest ? 16'sd0 : acc[31:16];
        otc_pkg::WB_SQ:   sq[ctl.uc.wb_idx]   <= acc[31:0];
        otc_pkg::WB_OUT:  corr[ctl.uc.wb_idx] <= acc[47:12];
        otc_pkg::WB_RAW: begin
          // The first sample seeds the filter and reports no correction.
          filt[0] <= v[0];
          filt[1] <= v[1];
          filt[2] <= v[2];
          corr[0] <= 36'sd0;
          corr[1] <= 36'sd0;
          corr[2] <= 36'sd0;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/otc_checker.sv
// ----------------------------------------------------------------------------
// Odometry twist correction port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "odometry_twist_correction_top_defines.svh"

module otc_checker (
  input logic               clk,
  input logic               rst,
  input logic               pready,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [35:0] corr_x,
  input logic signed [35:0] corr_y,
  input logic signed [35:0] corr_ang
);

  `OTC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(corr_x) && $stable(corr_y) && $stable(corr_ang), "stalled result beat changed or dropped")
  `OTC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "input taken while a sample is in work")
  `OTC_ASSERT_NEXT(a_no_instant_result, clk, rst, in_valid && in_ready, !$rose(out_valid), "result beat appeared right after acceptance")
  `OTC_ASSERT_ALWAYS(a_pready_high, clk, rst, pready, "register port inserted a wait state")
  `OTC_ASSERT_RESET(a_reset_state, clk, rst, !out_valid && in_ready, "block not idle after reset")

endmodule

bind odometry_twist_correction_top otc_checker u_otc_checker (.*);
